// ===== rtl/core/crt_pkg.sv =====
package crt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam int ID_W      = 16;
  localparam int TIME_W    = 31;
  localparam int SPEED_W   = 16;
  localparam int LEN_W     = 16;
  localparam int SUM_W     = LEN_W + 1;
  localparam int MS_W      = 10;
  localparam int PROD_W    = 27;
  localparam int WIDE_W    = TIME_W + 1;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [MS_W-1:0]   MS_PER_S      = 10'd1000;
  localparam logic [TIME_W-1:0] TIME_MAX      = '1;
  localparam logic [CFG_W-1:0]  LOOKAHEAD_RST = 16'd3000;

  // one quotient bit per step, one table entry per step
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_MAX   = (TABLE_DEPTH > DIV_STEPS) ? TABLE_DEPTH : DIV_STEPS;
  localparam int CNT_W     = $clog2(CNT_MAX);

  typedef enum logic [1:0] {
    CMD_APPROACH = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_LENGTH = 1'b0,
    CFG_LOOKAHEAD   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             load;
    logic             mul;
    logic             div_step;
    logic             scan_step;
    logic             write;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
  } dp_status_t;

endpackage

// ===== rtl/core/crt_if.sv =====
interface crt_in_if;
  import crt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [ID_W-1:0]    vehicle_id;
  logic [TIME_W-1:0]  arrival_time;
  logic [TIME_W-1:0]  query_leave_time;
  logic [SPEED_W-1:0] speed;
  logic [LEN_W-1:0]   vehicle_length;
  logic               will_pass;

  modport source (output valid, command, vehicle_id, arrival_time, query_leave_time,
                  speed, vehicle_length, will_pass, input ready);
  modport sink   (input valid, command, vehicle_id, arrival_time, query_leave_time,
                  speed, vehicle_length, will_pass, output ready);
endinterface

interface crt_out_if;
  import crt_pkg::*;
  logic              valid;
  logic              ready;
  logic              blocked;
  logic              status;
  logic [TIME_W-1:0] computed_leave_time;

  modport source (output valid, blocked, status, computed_leave_time, input ready);
  modport sink   (input valid, blocked, status, computed_leave_time, output ready);
endinterface

// ===== rtl/core/crt_ctrl.sv =====
module crt_ctrl
  import crt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_ready,
  input  dp_status_t sts,
  output logic       in_ready,
  output logic       out_valid,
  output ctrl_t      ctl
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_DIV    = 6'b000100,
    S_SCAN   = 6'b001000,
    S_WRITE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctl           = '0;
    ctl.idx       = cnt_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        ctl.mul = 1'b1;
        cnt_nxt = '0;
        unique case (sts.cmd) inside
          CMD_APPROACH:          state_nxt = S_DIV;
          CMD_REMOVE, CMD_QUERY: state_nxt = S_SCAN;
          default:               state_nxt = S_FINISH;
        endcase
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (cnt_r == CNT_W'(TABLE_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (sts.cmd == CMD_APPROACH) ? S_WRITE : S_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_WRITE: begin
        ctl.write = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/crt_datapath.sv =====
module crt_datapath
  import crt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctl,
  output dp_status_t         sts,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [1:0]         in_command,
  input  logic [ID_W-1:0]    in_vehicle_id,
  input  logic [TIME_W-1:0]  in_arrival_time,
  input  logic [TIME_W-1:0]  in_query_leave_time,
  input  logic [SPEED_W-1:0] in_speed,
  input  logic [LEN_W-1:0]   in_vehicle_length,
  input  logic               in_will_pass,
  output logic               out_blocked,
  output logic               out_status,
  output logic [TIME_W-1:0]  out_computed_leave_time
);

  // configuration and table occupancy
  logic [CFG_W-1:0]       link_r;
  logic [CFG_W-1:0]       look_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  // table contents
  logic [ID_W-1:0]   ent_vehicle_r [TABLE_DEPTH];
  logic [TIME_W-1:0] ent_arrival_r [TABLE_DEPTH];
  logic [TIME_W-1:0] ent_leave_r   [TABLE_DEPTH];
  logic              ent_passes_r  [TABLE_DEPTH];

  // captured command
  cmd_t               cmd_r;
  logic [ID_W-1:0]    id_r;
  logic [TIME_W-1:0]  arr_r;
  logic [TIME_W-1:0]  qleave_r;
  logic [SPEED_W-1:0] speed_r;
  logic [LEN_W-1:0]   vlen_r;
  logic               pass_r;

  // divider and scan state
  logic [PROD_W-1:0]  quo_r;
  logic [SPEED_W-1:0] rem_r;
  logic               found_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               blocked_r;

  logic               out_blocked_r;
  logic               out_status_r;
  logic [TIME_W-1:0]  out_leave_r;

  logic [SUM_W-1:0]   len_sum;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   rem_sh;
  logic               q_bit;
  logic [ID_W-1:0]    rd_vehicle;
  logic [TIME_W-1:0]  rd_arrival;
  logic [TIME_W-1:0]  rd_leave;
  logic               rd_passes;
  logic               rd_valid;
  logic               id_hit;
  logic               slot_free;
  logic [WIDE_W-1:0]  win_end;
  logic [WIDE_W-1:0]  q_end;
  logic               overlap;
  logic               pass_hit;
  logic [WIDE_W-1:0]  leave_sum;
  logic [TIME_W-1:0]  leave;

  assign sts.cmd = cmd_r;

  assign len_sum = SUM_W'(vlen_r) + SUM_W'(link_r);
  assign prod    = PROD_W'(len_sum) * PROD_W'(MS_PER_S);

  // restoring division, one quotient bit per step
  assign rem_sh = {rem_r, quo_r[PROD_W-1]};
  assign q_bit  = (rem_sh >= SUM_W'(speed_r));

  assign rd_vehicle = ent_vehicle_r[ctl.idx];
  assign rd_arrival = ent_arrival_r[ctl.idx];
  assign rd_leave   = ent_leave_r[ctl.idx];
  assign rd_passes  = ent_passes_r[ctl.idx];
  assign rd_valid   = valid_r[ctl.idx];

  // only the first entry with this id is dropped
  assign id_hit    = rd_valid && (rd_vehicle == id_r) && !found_r &&
                     ((cmd_r == CMD_APPROACH) || (cmd_r == CMD_REMOVE));
  assign slot_free = !rd_valid || id_hit;

  assign win_end  = WIDE_W'(rd_leave) + WIDE_W'(look_r);
  assign q_end    = WIDE_W'(qleave_r) + WIDE_W'(look_r);
  assign overlap  = !((win_end < WIDE_W'(arr_r)) || (WIDE_W'(rd_arrival) > q_end));
  assign pass_hit = rd_valid && rd_passes && overlap;

  assign leave_sum = WIDE_W'(arr_r) + WIDE_W'(quo_r);
  assign leave     = ((speed_r == '0) || leave_sum[WIDE_W-1]) ? TIME_MAX
                                                              : leave_sum[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r  <= '0;
      look_r  <= LOOKAHEAD_RST;
      valid_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LINK_LENGTH: link_r <= cfg_data;
          CFG_LOOKAHEAD:   look_r <= cfg_data;
        endcase
      end
      if (ctl.scan_step && id_hit) begin
        valid_r[ctl.idx] <= 1'b0;
      end
      if (ctl.write && free_found_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= cmd_t'(in_command);
      id_r     <= in_vehicle_id;
      arr_r    <= in_arrival_time;
      qleave_r <= in_query_leave_time;
      speed_r  <= in_speed;
      vlen_r   <= in_vehicle_length;
      pass_r   <= in_will_pass;
    end
    if (ctl.mul) begin
      quo_r        <= prod;
      rem_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      blocked_r    <= 1'b0;
    end
    if (ctl.div_step) begin
      quo_r <= {quo_r[PROD_W-2:0], q_bit};
      rem_r <= q_bit ? SPEED_W'(rem_sh - SUM_W'(speed_r)) : rem_sh[SPEED_W-1:0];
    end
    if (ctl.scan_step) begin
      if (id_hit) begin
        found_r <= 1'b1;
      end
      if (slot_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= ctl.idx;
      end
      if (cmd_r == CMD_QUERY && pass_hit) begin
        blocked_r <= 1'b1;
      end
    end
    if (ctl.write && free_found_r) begin
      ent_vehicle_r[free_idx_r] <= id_r;
      ent_arrival_r[free_idx_r] <= arr_r;
      ent_leave_r[free_idx_r]   <= leave;
      ent_passes_r[free_idx_r]  <= pass_r;
    end
    if (ctl.out_load) begin
      out_blocked_r <= (cmd_r == CMD_QUERY) && blocked_r;
      out_status_r  <= (cmd_r == CMD_APPROACH) && !free_found_r;
      out_leave_r   <= (cmd_r == CMD_APPROACH) ? leave : '0;
    end
  end

  assign out_blocked             = out_blocked_r;
  assign out_status              = out_status_r;
  assign out_computed_leave_time = out_leave_r;

endmodule

// ===== rtl/core/crossing_reservation_table_unit.sv =====
// Sequence: an approach runs from input transfer to result valid through multiply,
//   27-step serial divide, scan of TABLE_DEPTH entries, write and result load;
//   remove and query: multiply, scan, result load; command three: multiply, result load.
// Flow: one command at a time; the next can be taken in the cycle after the result is
//   loaded into the output register.
// Reset: synchronous, active low; clears all table valid bits, sets link_length to 0
//   and lookahead_ms to 3000, and empties the result register. No clearing pass.
module crossing_reservation_table_unit
  import crt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  crt_in_if.sink               in_ch,
  crt_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctrl_t      ctl;
  dp_status_t sts;

  crt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .ctl       (ctl)
  );

  crt_datapath u_datapath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .ctl                     (ctl),
    .sts                     (sts),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_command              (in_ch.command),
    .in_vehicle_id           (in_ch.vehicle_id),
    .in_arrival_time         (in_ch.arrival_time),
    .in_query_leave_time     (in_ch.query_leave_time),
    .in_speed                (in_ch.speed),
    .in_vehicle_length       (in_ch.vehicle_length),
    .in_will_pass            (in_ch.will_pass),
    .out_blocked             (out_ch.blocked),
    .out_status              (out_ch.status),
    .out_computed_leave_time (out_ch.computed_leave_time)
  );

  // a new result shows only after a load from the controller
  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctl.out_load))
    else $error("result valid rose without a load");

  // one command in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a command is in flight");

  // table write follows the end of the scan
  a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.write |-> $past(ctl.scan_step))
    else $error("table write without a finished scan");

  // loading the result register never overwrites a pending result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

endmodule
